FILE: sv/cslc_pkg.sv
// ----------------------------------------------------------------------------
// cslc_pkg - shared types and constants for the C source line classifier
// Character codes, opcodes, counter slots and the blank-character test.
// ----------------------------------------------------------------------------
package cslc_pkg;

    localparam int OUT_BITS = 32;   // width of each reported counter field
    localparam int NUM_CNT  = 5;

    typedef logic [7:0] char_t;
    typedef logic [2:0] cnt_idx_t;

    // opcodes
    localparam logic OP_CHAR  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // counter slots
    localparam cnt_idx_t CNT_TOTAL   = 3'd0;
    localparam cnt_idx_t CNT_BLANK   = 3'd1;
    localparam cnt_idx_t CNT_CODE    = 3'd2;
    localparam cnt_idx_t CNT_COMMENT = 3'd3;
    localparam cnt_idx_t CNT_INLINE  = 3'd4;

    // characters of interest
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_SLASH  = 8'h2F;
    localparam char_t CH_BSLASH = 8'h5C;
    localparam char_t CH_DQUOTE = 8'h22;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_CR     = 8'h0D;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

FILE: sv/c_source_line_classifier.sv
// ----------------------------------------------------------------------------
// c_source_line_classifier - per-line sorter and counter for C source text
// Character-per-beat parser with saturating line-class counters.
// ----------------------------------------------------------------------------
// One character beat in, one result beat out, one beat per clock sustained while out_ready stays high.
// A beat goes through an input register, is parsed against the state left by
// the beat before it, and lands in the result register when that is free or
// being emptied; while a result waits the input register takes one more beat
// and then holds in_ready low until the result is taken. The
// parser tracks block comments, strings with backslash escapes and the rest of
// a line after a double slash, looking one character ahead for slash-star,
// star-slash and double slash. The star that opens a block comment counts as
// comment text, so slash-star-slash opens and shuts a comment. A beat flagged
// line_end closes the line: total plus exactly one of blank, code or comment
// only is bumped, and inline as well for code lines with comment text. Counters
// are COUNT_BITS wide, saturate, and report their low 32 bits. A clear beat
// zeroes all counters and parser state and reports zeros with line_done low.
// ----------------------------------------------------------------------------
module c_source_line_classifier #(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  char_code,
    input  logic        line_end,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] total_lines,
    output logic [31:0] blank_lines,
    output logic [31:0] code_lines,
    output logic [31:0] comment_only_lines,
    output logic [31:0] inline_comment_lines,
    output logic        line_done
);

    localparam int OUT_W = cslc_pkg::OUT_BITS;
    localparam int MIN_W = (COUNT_BITS < OUT_W) ? COUNT_BITS : OUT_W;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [OUT_W-1:0]      outw_t;

    // input register stage
    logic               s1_valid_reg;
    logic               s1_opcode_reg;
    cslc_pkg::char_t    s1_char_reg;
    logic               s1_end_reg;

    // parser state
    logic in_block_reg,    in_block_next;
    logic in_string_reg,   in_string_next;
    logic escape_reg,      escape_next;
    logic skip_reg,        skip_next;
    logic held_valid_reg,  held_valid_next;
    logic has_code_reg,    has_code_next;
    logic has_comment_reg, has_comment_next;
    cnt_t cnt_reg  [cslc_pkg::NUM_CNT];
    cnt_t cnt_next [cslc_pkg::NUM_CNT];

    // result register
    logic  out_valid_reg;
    outw_t res_reg  [cslc_pkg::NUM_CNT];
    outw_t res_next [cslc_pkg::NUM_CNT];
    logic  done_reg, done_next;

    logic s1_go;
    logic consumed;

    // stage 1 moves on when the result register is free or being emptied
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    // ---- parse one character against the current state ----
    always_comb
    begin
        in_block_next    = in_block_reg;
        in_string_next   = in_string_reg;
        escape_next      = escape_reg;
        skip_next        = skip_reg;
        held_valid_next  = held_valid_reg;
        has_code_next    = has_code_reg;
        has_comment_next = has_comment_reg;
        done_next        = 1'b0;
        consumed         = 1'b0;
        for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end

        if (s1_opcode_reg == cslc_pkg::OP_CLEAR)
        begin
            in_block_next    = 1'b0;
            in_string_next   = 1'b0;
            escape_next      = 1'b0;
            skip_next        = 1'b0;
            held_valid_next  = 1'b0;
            has_code_next    = 1'b0;
            has_comment_next = 1'b0;
            for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
            begin
                cnt_next[k] = '0;
            end
        end
        else
        begin
            if (!skip_reg)
            begin
                // resolve the held slash or star against this character
                if (held_valid_reg)
                begin
                    held_valid_next = 1'b0;
                    if (in_block_reg)
                    begin
                        if (s1_char_reg == cslc_pkg::CH_SLASH)
                        begin
                            in_block_next = 1'b0;
                            consumed      = 1'b1;
                        end
                    end
                    else if (s1_char_reg == cslc_pkg::CH_STAR)
                    begin
                        in_block_next    = 1'b1;
                        has_comment_next = 1'b1;
                    end
                    else if (s1_char_reg == cslc_pkg::CH_SLASH)
                    begin
                        has_comment_next = 1'b1;
                        skip_next        = 1'b1;
                        consumed         = 1'b1;
                    end
                    else
                    begin
                        has_code_next = 1'b1;
                    end
                end

                // ordinary handling (note: sees the updated modes)
                if (!consumed && !skip_next)
                begin
                    if (escape_reg)
                    begin
                        escape_next = 1'b0;
                    end
                    else if (cslc_pkg::is_blank(s1_char_reg))
                    begin
                    end
                    else if (in_block_next)
                    begin
                        has_comment_next = 1'b1;
                        if (s1_char_reg == cslc_pkg::CH_STAR)
                        begin
                            held_valid_next = 1'b1;
                        end
                    end
                    else if (in_string_reg)
                    begin
                        has_code_next = 1'b1;
                        if (s1_char_reg == cslc_pkg::CH_BSLASH)
                        begin
                            escape_next = 1'b1;
                        end
                        else if (s1_char_reg == cslc_pkg::CH_DQUOTE)
                        begin
                            in_string_next = 1'b0;
                        end
                    end
                    else if (s1_char_reg == cslc_pkg::CH_SLASH)
                    begin
                        held_valid_next = 1'b1;
                    end
                    else
                    begin
                        has_code_next = 1'b1;
                        if (s1_char_reg == cslc_pkg::CH_DQUOTE)
                        begin
                            in_string_next = 1'b1;
                        end
                    end
                end
            end

            if (s1_end_reg)
            begin
                // a lone slash left at line end is code; a held star is not
                if (held_valid_next && !skip_next && !in_block_next)
                begin
                    has_code_next = 1'b1;
                end

                if (cnt_reg[cslc_pkg::CNT_TOTAL] != '1)
                begin
                    cnt_next[cslc_pkg::CNT_TOTAL] = cnt_reg[cslc_pkg::CNT_TOTAL] + cnt_t'(1);
                end
                if (has_code_next)
                begin
                    if (cnt_reg[cslc_pkg::CNT_CODE] != '1)
                    begin
                        cnt_next[cslc_pkg::CNT_CODE] = cnt_reg[cslc_pkg::CNT_CODE] + cnt_t'(1);
                    end
                    if (has_comment_next && (cnt_reg[cslc_pkg::CNT_INLINE] != '1))
                    begin
                        cnt_next[cslc_pkg::CNT_INLINE] =
                            cnt_reg[cslc_pkg::CNT_INLINE] + cnt_t'(1);
                    end
                end
                else if (has_comment_next)
                begin
                    if (cnt_reg[cslc_pkg::CNT_COMMENT] != '1)
                    begin
                        cnt_next[cslc_pkg::CNT_COMMENT] =
                            cnt_reg[cslc_pkg::CNT_COMMENT] + cnt_t'(1);
                    end
                end
                else if (cnt_reg[cslc_pkg::CNT_BLANK] != '1)
                begin
                    cnt_next[cslc_pkg::CNT_BLANK] = cnt_reg[cslc_pkg::CNT_BLANK] + cnt_t'(1);
                end

                has_code_next    = 1'b0;
                has_comment_next = 1'b0;
                skip_next        = 1'b0;
                escape_next      = 1'b0;
                held_valid_next  = 1'b0;
                done_next        = 1'b1;
            end
        end

        // report the low bits, zero-extended when counters are narrow
        for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
        begin
            res_next[k]            = '0;
            res_next[k][MIN_W-1:0] = cnt_next[k][MIN_W-1:0];
        end
    end

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            in_block_reg    <= 1'b0;
            in_string_reg   <= 1'b0;
            escape_reg      <= 1'b0;
            skip_reg        <= 1'b0;
            held_valid_reg  <= 1'b0;
            has_code_reg    <= 1'b0;
            has_comment_reg <= 1'b0;
            for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (s1_go)
            begin
                out_valid_reg   <= 1'b1;
                in_block_reg    <= in_block_next;
                in_string_reg   <= in_string_next;
                escape_reg      <= escape_next;
                skip_reg        <= skip_next;
                held_valid_reg  <= held_valid_next;
                has_code_reg    <= has_code_next;
                has_comment_reg <= has_comment_next;
                for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
                begin
                    cnt_reg[k] <= cnt_next[k];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_opcode_reg <= opcode;
            s1_char_reg   <= char_code;
            s1_end_reg    <= line_end;
        end
        if (s1_go)
        begin
            done_reg <= done_next;
            for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
            begin
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign out_valid            = out_valid_reg;
    assign total_lines          = res_reg[cslc_pkg::CNT_TOTAL];
    assign blank_lines          = res_reg[cslc_pkg::CNT_BLANK];
    assign code_lines           = res_reg[cslc_pkg::CNT_CODE];
    assign comment_only_lines   = res_reg[cslc_pkg::CNT_COMMENT];
    assign inline_comment_lines = res_reg[cslc_pkg::CNT_INLINE];
    assign line_done            = done_reg;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the C source line classifier
// Feeds character beats and checks every result beat against a line predictor or a typed expectation.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats comes first. It covers character
// extremes, whitespace bounds, slash-star-slash, lookahead at line end, line
// comments, escapes and the clear beat. Random lines of C-like text follow.
// Both sides idle at random. Once the result side holds off long enough to
// back up the input, and once the feed waits for all results to drain.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CNT_W     = 32;      // counter width inside the block
    localparam int N_RANDOM  = 1100;
    localparam int HOLD_AT   = 250;     // beats accepted before the long hold-off
    localparam int HOLD_LEN  = 300;     // cycles of that hold-off
    localparam int PAUSE_AT  = 500;     // feed drains the pipe before this beat
    localparam int CALM_LO   = 700;     // no idling on either side in this window
    localparam int CALM_HI   = 900;
    localparam int IDLE_PCT  = 15;

    typedef struct packed {
        logic [cslc_pkg::NUM_CNT-1:0][cslc_pkg::OUT_BITS-1:0] cnt;
        logic                                                 done;
    } tally_t;

    typedef struct packed {
        logic            op;
        cslc_pkg::char_t ch;
        logic            eol;
        logic            known;      // expectation typed into the table
        tally_t          want;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = cslc_pkg::OP_CHAR;
    logic [7:0]  char_code = 8'h00;
    logic        line_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] total_lines;
    logic [31:0] blank_lines;
    logic [31:0] code_lines;
    logic [31:0] comment_only_lines;
    logic [31:0] inline_comment_lines;
    logic        line_done;

    c_source_line_classifier #(.COUNT_BITS(CNT_W)) uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .opcode               (opcode),
        .char_code            (char_code),
        .line_end             (line_end),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .total_lines          (total_lines),
        .blank_lines          (blank_lines),
        .code_lines           (code_lines),
        .comment_only_lines   (comment_only_lines),
        .inline_comment_lines (inline_comment_lines),
        .line_done            (line_done)
    );

    always #5 clk = ~clk;

    beat_t  stim_q[$];
    tally_t tally_q[$];         // expected result beats, oldest first
    int     n_accepted = 0;
    int     n_results  = 0;
    int     n_errors   = 0;

    // ------------------------------------------------------------------
    // Line predictor: parser flags and saturating counters
    // ------------------------------------------------------------------
    logic             in_cmt, in_str, esc_due, skip_line;
    cslc_pkg::char_t  held_ch;
    logic             held;
    logic             seen_code, seen_cmt;
    logic [CNT_W-1:0] lines_cnt [cslc_pkg::NUM_CNT];

    function automatic void clear_parser();
        in_cmt    = 1'b0;
        in_str    = 1'b0;
        esc_due   = 1'b0;
        skip_line = 1'b0;
        held_ch   = '0;
        held      = 1'b0;
        seen_code = 1'b0;
        seen_cmt  = 1'b0;
        for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
            lines_cnt[k] = '0;
    endfunction

    function automatic logic white(cslc_pkg::char_t c);
        return (c == cslc_pkg::CH_SPACE) || (c inside {[cslc_pkg::CH_TAB:cslc_pkg::CH_CR]});
    endfunction

    function automatic void bump_count(cslc_pkg::cnt_idx_t k);
        if (lines_cnt[k] != {CNT_W{1'b1}})
            lines_cnt[k] = lines_cnt[k] + CNT_W'(1);
    endfunction

    // a character not swallowed by the lookahead
    function automatic void absorb_char(cslc_pkg::char_t c);
        if (esc_due)
            esc_due = 1'b0;
        else if (!white(c)) begin
            if (in_cmt) begin
                seen_cmt = 1'b1;
                if (c == cslc_pkg::CH_STAR) begin
                    held_ch = c;
                    held    = 1'b1;
                end
            end else if (in_str) begin
                seen_code = 1'b1;
                if (c == cslc_pkg::CH_BSLASH)
                    esc_due = 1'b1;
                else if (c == cslc_pkg::CH_DQUOTE)
                    in_str = 1'b0;
            end else if (c == cslc_pkg::CH_SLASH) begin
                held_ch = c;
                held    = 1'b1;
            end else begin
                seen_code = 1'b1;
                if (c == cslc_pkg::CH_DQUOTE)
                    in_str = 1'b1;
            end
        end
    endfunction

    // pair the held character with its successor; 1 when the successor is used up
    function automatic logic settle_held(logic has_next, cslc_pkg::char_t n);
        held = 1'b0;
        if (in_cmt) begin
            if (has_next && n == cslc_pkg::CH_SLASH) begin
                in_cmt = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (has_next && n == cslc_pkg::CH_STAR) begin
            in_cmt   = 1'b1;
            seen_cmt = 1'b1;
            return 1'b0;
        end
        if (has_next && n == cslc_pkg::CH_SLASH) begin
            seen_cmt  = 1'b1;
            skip_line = 1'b1;
            return 1'b1;
        end
        seen_code = 1'b1;
        return 1'b0;
    endfunction

    function automatic void close_line();
        bump_count(cslc_pkg::CNT_TOTAL);
        if (seen_code) begin
            bump_count(cslc_pkg::CNT_CODE);
            if (seen_cmt)
                bump_count(cslc_pkg::CNT_INLINE);
        end else if (seen_cmt)
            bump_count(cslc_pkg::CNT_COMMENT);
        else
            bump_count(cslc_pkg::CNT_BLANK);
        seen_code = 1'b0;
        seen_cmt  = 1'b0;
        skip_line = 1'b0;
        esc_due   = 1'b0;
        held      = 1'b0;
        held_ch   = '0;
    endfunction

    function automatic tally_t classify_beat(logic op, cslc_pkg::char_t c, logic eol);
        tally_t t;
        logic   used;
        t    = '0;
        used = 1'b0;
        if (op == cslc_pkg::OP_CLEAR)
            clear_parser();
        else begin
            if (!skip_line) begin
                if (held)
                    used = settle_held(1'b1, c);
                if (!used && !skip_line)
                    absorb_char(c);
            end
            if (eol) begin
                if (held && !skip_line)
                    void'(settle_held(1'b0, 8'h00));
                close_line();
                t.done = 1'b1;
            end
        end
        for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
            t.cnt[k] = lines_cnt[k][cslc_pkg::OUT_BITS-1:0];
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus table
    // ------------------------------------------------------------------
    function automatic void add_beat(logic op, cslc_pkg::char_t c, logic eol);
        beat_t b;
        b     = '0;
        b.op  = op;
        b.ch  = c;
        b.eol = eol;
        stim_q.push_back(b);
    endfunction

    function automatic void add_known(logic op, cslc_pkg::char_t c, logic eol, int tot,
                                      int blk, int cod, int cmt, int inl, logic dn);
        beat_t b;
        b                                = '0;
        b.op                             = op;
        b.ch                             = c;
        b.eol                            = eol;
        b.known                          = 1'b1;
        b.want.cnt[cslc_pkg::CNT_TOTAL]   = tot;
        b.want.cnt[cslc_pkg::CNT_BLANK]   = blk;
        b.want.cnt[cslc_pkg::CNT_CODE]    = cod;
        b.want.cnt[cslc_pkg::CNT_COMMENT] = cmt;
        b.want.cnt[cslc_pkg::CNT_INLINE]  = inl;
        b.want.done                      = dn;
        stim_q.push_back(b);
    endfunction

    // one line of text, last character flagged as line end
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(cslc_pkg::OP_CHAR, s[i], i == s.len() - 1);
    endfunction

    function automatic cslc_pkg::char_t pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 15)      return cslc_pkg::CH_SLASH;
        else if (r < 27) return cslc_pkg::CH_STAR;
        else if (r < 35) return cslc_pkg::CH_DQUOTE;
        else if (r < 40) return cslc_pkg::CH_BSLASH;
        else if (r < 52) return cslc_pkg::CH_SPACE;
        else if (r < 56)
            return cslc_pkg::char_t'($urandom_range(cslc_pkg::CH_TAB, cslc_pkg::CH_CR));
        else if (r < 90) return cslc_pkg::char_t'(8'h61 + $urandom_range(25));
        else             return cslc_pkg::char_t'($urandom_range(255));
    endfunction

    function automatic void build_stimulus();
        int len;
        // first line after reset, then clear with the other fields set
        add_known(cslc_pkg::OP_CHAR, 8'h61, 1'b1, 1, 0, 1, 0, 0, 1'b1);
        add_known(cslc_pkg::OP_CLEAR, 8'hFF, 1'b1, 0, 0, 0, 0, 0, 1'b0);
        // byte extremes are code, tab is blank
        add_known(cslc_pkg::OP_CHAR, 8'hFF, 1'b1, 1, 0, 1, 0, 0, 1'b1);
        add_known(cslc_pkg::OP_CHAR, 8'h00, 1'b1, 2, 0, 2, 0, 0, 1'b1);
        add_known(cslc_pkg::OP_CHAR, cslc_pkg::CH_TAB, 1'b1, 3, 1, 2, 0, 0, 1'b1);
        add_beat(cslc_pkg::OP_CHAR, cslc_pkg::CH_CR, 1'b1);
        add_beat(cslc_pkg::OP_CHAR, 8'h0E, 1'b1);
        add_text("/*/");            // opening star is comment text: shut at once
        add_text("/");              // held slash meets line end: code
        add_text("x//\"");          // line comment hides the quote
        add_text("\"\\\"\"");       // escaped quote inside a string
        add_text("\"\\");           // escape dropped at line end, string goes on
        add_text("\"");
        add_text("/*");             // block comment runs into the next line
        add_text("*/z");
        add_beat(cslc_pkg::OP_CLEAR, 8'h00, 1'b0);

        while (stim_q.size() < 26 + N_RANDOM) begin
            if ($urandom_range(49) == 0)
                add_beat(cslc_pkg::OP_CLEAR, cslc_pkg::char_t'($urandom_range(255)),
                         1'($urandom_range(1)));
            else begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_beat(cslc_pkg::OP_CHAR, pick_char(), i == len - 1);
            end
        end
    endfunction

    function automatic logic calm();
        return n_accepted >= CALM_LO && n_accepted < CALM_HI;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        if (n_errors <= 50)
            $display("mismatch on result %0d: %s got %0d want %0d", n_results, what, got,
                     want);
    endtask

    // ------------------------------------------------------------------
    // Feed side: one beat per table row, prediction at acceptance
    // ------------------------------------------------------------------
    initial begin : feed_side
        beat_t  row;
        tally_t t;
        int     gap;
        clear_parser();
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < stim_q.size(); i++) begin
            row = stim_q[i];
            gap = (!calm() && $urandom_range(99) < IDLE_PCT) ? 1 : 0;
            if (gap > 0 || i == PAUSE_AT) begin
                in_valid <= 1'b0;
                @(posedge clk);
                repeat ((gap > 0) ? gap - 1 : 0) @(posedge clk);
                if (i == PAUSE_AT)
                    while (tally_q.size() != 0) @(posedge clk);
            end
            in_valid  <= 1'b1;
            opcode    <= row.op;
            char_code <= row.ch;
            line_end  <= row.eol;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            t = classify_beat(row.op, row.ch, row.eol);
            tally_q.push_back(row.known ? row.want : t);
            n_accepted++;
        end
        in_valid <= 1'b0;
        while (tally_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: compare each beat, random stalls, one long hold-off
    // ------------------------------------------------------------------
    initial begin : drain_side
        tally_t want;
        tally_t got;
        int     hold_left;
        logic   hold_done;
        string  names [cslc_pkg::NUM_CNT];
        names     = '{"total_lines", "blank_lines", "code_lines", "comment_only_lines",
                      "inline_comment_lines"};
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.cnt  = {inline_comment_lines, comment_only_lines, code_lines,
                            blank_lines, total_lines};
                got.done = line_done;
                if (tally_q.size() == 0)
                    report_mismatch("result with nothing pending", 0, 0);
                else begin
                    want = tally_q.pop_front();
                    for (int k = 0; k < cslc_pkg::NUM_CNT; k++)
                        if (got.cnt[k] !== want.cnt[k])
                            report_mismatch(names[k], got.cnt[k], want.cnt[k]);
                    if (got.done !== want.done)
                        report_mismatch("line_done", 32'(got.done), 32'(want.done));
                end
                n_results++;
            end
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else
                out_ready <= calm() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
